@@ design/pidc_pkg.sv @@
// pidc_pkg: shared types, constants, microcode table and arithmetic helpers
`default_nettype none

package pidc_pkg;

    // widths
    localparam int DATA_W    = 32;
    localparam int STEP_W    = 16;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int DIV_W     = DATA_W + FRAC_W;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int UPC_W     = 5;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic [STEP_W-1:0]        step_t;
    typedef logic [DIV_W-1:0]         div_t;
    typedef logic [DIV_CNT_W-1:0]     div_cnt_t;
    typedef logic [UPC_W-1:0]         upc_t;

    // saturation limits held at product width
    localparam prod_t S32_MAX = 64'sd2147483647;
    localparam prod_t S32_MIN = -64'sd2147483648;

    // register reset values
    localparam word_t PROP_GAIN_RST  = 32'sd65536;
    localparam word_t INTEG_GAIN_RST = 32'sd0;
    localparam word_t DERIV_GAIN_RST = 32'sd0;
    localparam word_t OUT_SCALE_RST  = 32'sd65536;
    localparam word_t OUT_LOW_RST    = -32'sd2147483648;
    localparam word_t OUT_HIGH_RST   = 32'sd2147483647;
    localparam word_t INTEG_LOW_RST  = -32'sd2147483648;
    localparam word_t INTEG_HIGH_RST = 32'sd2147483647;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN  = 3'd0,
        CFG_INTEG_GAIN = 3'd1,
        CFG_DERIV_GAIN = 3'd2,
        CFG_OUT_SCALE  = 3'd3,
        CFG_OUT_LOW    = 3'd4,
        CFG_OUT_HIGH   = 3'd5,
        CFG_INTEG_LOW  = 3'd6,
        CFG_INTEG_HIGH = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        word_t prop_gain;
        word_t integ_gain;
        word_t deriv_gain;
        word_t out_scale;
        word_t out_low;
        word_t out_high;
        word_t integ_low;
        word_t integ_high;
    } cfg_t;

    // micro-operations of the datapath
    typedef enum logic [4:0] {
        OP_NOP,
        OP_CLEAR,
        OP_DIFF,
        OP_MUL_DD,
        OP_DIV_GO,
        OP_MUL_PE,
        OP_SET_P,
        OP_MUL_IE,
        OP_SET_K,
        OP_MUL_KT,
        OP_ACC_I,
        OP_CLAMP_I,
        OP_SET_D,
        OP_SUM,
        OP_MUL_SS,
        OP_SET_S,
        OP_OUT
    } uop_t;

    // jump conditions
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_START,
        COND_UPDATE,
        COND_DT_ZERO,
        COND_INTEG_OFF,
        COND_DIV_BUSY,
        COND_OUT_BUSY
    } ucond_t;

    typedef struct packed {
        uop_t   op;
        ucond_t cond;
        upc_t   target;
    } uword_t;

    // status from datapath to sequencer
    typedef struct packed {
        logic mode_clear;
        logic dt_zero;
        logic integ_off;
        logic div_busy;
    } dp_flags_t;

    // program addresses
    localparam upc_t UA_IDLE     = 5'd0;
    localparam upc_t UA_UPDATE   = 5'd3;
    localparam upc_t UA_SKIP_DIV = 5'd6;
    localparam upc_t UA_WAIT_DIV = 5'd13;
    localparam upc_t UA_OUT      = 5'd18;

    // microcode program
    function automatic uword_t ucode_word(input upc_t addr);
        uword_t w;
        unique case (addr)
            5'd0:  w = '{OP_NOP,     COND_NO_START,  UA_IDLE};
            5'd1:  w = '{OP_NOP,     COND_UPDATE,    UA_UPDATE};
            5'd2:  w = '{OP_CLEAR,   COND_ALWAYS,    UA_IDLE};
            5'd3:  w = '{OP_DIFF,    COND_NEVER,     UA_IDLE};
            5'd4:  w = '{OP_MUL_DD,  COND_DT_ZERO,   UA_SKIP_DIV};
            5'd5:  w = '{OP_DIV_GO,  COND_NEVER,     UA_IDLE};
            5'd6:  w = '{OP_MUL_PE,  COND_NEVER,     UA_IDLE};
            5'd7:  w = '{OP_SET_P,   COND_INTEG_OFF, UA_WAIT_DIV};
            5'd8:  w = '{OP_MUL_IE,  COND_NEVER,     UA_IDLE};
            5'd9:  w = '{OP_SET_K,   COND_NEVER,     UA_IDLE};
            5'd10: w = '{OP_MUL_KT,  COND_NEVER,     UA_IDLE};
            5'd11: w = '{OP_ACC_I,   COND_NEVER,     UA_IDLE};
            5'd12: w = '{OP_CLAMP_I, COND_NEVER,     UA_IDLE};
            5'd13: w = '{OP_NOP,     COND_DIV_BUSY,  UA_WAIT_DIV};
            5'd14: w = '{OP_SET_D,   COND_NEVER,     UA_IDLE};
            5'd15: w = '{OP_SUM,     COND_NEVER,     UA_IDLE};
            5'd16: w = '{OP_MUL_SS,  COND_NEVER,     UA_IDLE};
            5'd17: w = '{OP_SET_S,   COND_NEVER,     UA_IDLE};
            5'd18: w = '{OP_OUT,     COND_OUT_BUSY,  UA_OUT};
            default: w = '{OP_NOP,   COND_ALWAYS,    UA_IDLE};
        endcase
        return w;
    endfunction

    // saturate a wide signed value to 32 bits
    function automatic word_t sat64(input prod_t v);
        word_t r;
        if (v > S32_MAX)
        begin
            r = word_t'(S32_MAX[DATA_W-1:0]);
        end
        else if (v < S32_MIN)
        begin
            r = word_t'(S32_MIN[DATA_W-1:0]);
        end
        else
        begin
            r = word_t'(v[DATA_W-1:0]);
        end
        return r;
    endfunction

    // upper limit tested first
    function automatic word_t clamp32(input word_t v, input word_t lo, input word_t hi);
        word_t r;
        if (v > hi)
        begin
            r = hi;
        end
        else if (v < lo)
        begin
            r = lo;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/pidc_div.sv @@
// pidc_div: unsigned serial divider, two quotient bits per cycle
`default_nettype none

module pidc_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire pidc_pkg::div_t   dividend,
    input  wire pidc_pkg::step_t  divisor,
    output logic                  busy,
    output pidc_pkg::div_t        quotient
);

    logic                busy_reg, busy_next;
    pidc_pkg::div_cnt_t  cnt_reg, cnt_next;
    pidc_pkg::step_t     rem_reg;
    pidc_pkg::step_t     dsr_reg;
    pidc_pkg::div_t      quo_reg;

    logic [pidc_pkg::STEP_W:0]   t1, t2, d17;
    logic [pidc_pkg::STEP_W:0]   r1_full, r2_full;
    logic                        ge1, ge2;

    // two restoring subtract steps
    always_comb
    begin
        d17     = {1'b0, dsr_reg};
        t1      = {rem_reg, quo_reg[pidc_pkg::DIV_W-1]};
        ge1     = (t1 >= d17);
        r1_full = ge1 ? (t1 - d17) : t1;
        t2      = {r1_full[pidc_pkg::STEP_W-1:0], quo_reg[pidc_pkg::DIV_W-2]};
        ge2     = (t2 >= d17);
        r2_full = ge2 ? (t2 - d17) : t2;
    end

    // iteration control
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = pidc_pkg::div_cnt_t'(pidc_pkg::DIV_STEPS - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // remainder and shifting dividend / quotient word
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[pidc_pkg::DIV_W-3:0], ge1, ge2};
            rem_reg <= r2_full[pidc_pkg::STEP_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

    // a new division must not cut into a running one
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

`default_nettype wire

@@ design/pidc_dpath.sv @@
// pidc_dpath: controller datapath with shared multiplier and state registers
`default_nettype none

module pidc_dpath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pidc_pkg::cfg_t      cfg,
    input  wire pidc_pkg::uword_t    ctrl,
    input  wire logic                load,
    input  wire logic                mode,
    input  wire pidc_pkg::word_t     error_in,
    input  wire pidc_pkg::step_t     step_ms,
    output pidc_pkg::dp_flags_t      flags,
    output pidc_pkg::word_t          drive_val
);

    // latched input word
    logic                mode_reg;
    pidc_pkg::word_t     err_reg;
    pidc_pkg::step_t     dt_reg;

    // controller state
    pidc_pkg::word_t     integral_reg, integral_next;
    pidc_pkg::word_t     prev_error_reg, prev_error_next;
    logic                have_prev_reg, have_prev_next;

    // working registers
    pidc_pkg::word_t     diff_reg;
    pidc_pkg::prod_t     prod_reg;
    pidc_pkg::word_t     p_reg;
    pidc_pkg::word_t     iterm_reg;
    pidc_pkg::word_t     d_reg;
    pidc_pkg::word_t     acc_reg;
    logic                div_neg_reg;

    pidc_pkg::word_t     mul_a, mul_b;
    pidc_pkg::prod_t     mul_p;
    pidc_pkg::prod_t     prod_shr;
    logic signed [pidc_pkg::DATA_W:0]   diff_wide;
    logic signed [pidc_pkg::DATA_W:0]   isum_wide;
    logic signed [pidc_pkg::DATA_W+1:0] tsum_wide;
    pidc_pkg::word_t     term;
    pidc_pkg::word_t     integ_clamped;
    logic signed [pidc_pkg::DIV_W-1:0]  dvd;
    pidc_pkg::div_t      dvd_mag;
    logic signed [pidc_pkg::DIV_W:0]    quo_signed;
    logic                div_busy;
    pidc_pkg::div_t      div_quo;

    // multiplier operand selection
    always_comb
    begin
        mul_a = cfg.prop_gain;
        mul_b = err_reg;
        unique case (ctrl.op)
            pidc_pkg::OP_MUL_DD:
            begin
                mul_a = cfg.deriv_gain;
                mul_b = diff_reg;
            end
            pidc_pkg::OP_MUL_IE:
            begin
                mul_a = cfg.integ_gain;
                mul_b = err_reg;
            end
            pidc_pkg::OP_MUL_KT:
            begin
                mul_a = acc_reg;
                mul_b = pidc_pkg::word_t'({{(pidc_pkg::DATA_W-pidc_pkg::STEP_W){1'b0}}, dt_reg});
            end
            pidc_pkg::OP_MUL_SS:
            begin
                mul_a = acc_reg;
                mul_b = cfg.out_scale;
            end
            default:
            begin
                mul_a = cfg.prop_gain;
                mul_b = err_reg;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // arithmetic around the product register
    always_comb
    begin
        prod_shr      = prod_reg >>> pidc_pkg::FRAC_W;
        diff_wide     = (pidc_pkg::DATA_W+1)'(err_reg) - (pidc_pkg::DATA_W+1)'(prev_error_reg);
        term          = pidc_pkg::sat64(prod_reg);
        isum_wide     = (pidc_pkg::DATA_W+1)'(integral_reg) + (pidc_pkg::DATA_W+1)'(term);
        tsum_wide     = (pidc_pkg::DATA_W+2)'(p_reg) + (pidc_pkg::DATA_W+2)'(iterm_reg)
                      + (pidc_pkg::DATA_W+2)'(d_reg);
        integ_clamped = pidc_pkg::clamp32(integral_reg, cfg.integ_low, cfg.integ_high);
        dvd           = prod_reg[pidc_pkg::PROD_W-1:pidc_pkg::FRAC_W];
        dvd_mag       = dvd[pidc_pkg::DIV_W-1] ? pidc_pkg::div_t'(-dvd) : pidc_pkg::div_t'(dvd);
        quo_signed    = div_neg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    end

    // state updates
    always_comb
    begin
        integral_next   = integral_reg;
        prev_error_next = prev_error_reg;
        have_prev_next  = have_prev_reg;
        unique case (ctrl.op)
            pidc_pkg::OP_CLEAR:
            begin
                integral_next   = '0;
                prev_error_next = '0;
            end
            pidc_pkg::OP_DIFF:
            begin
                prev_error_next = err_reg;
                have_prev_next  = 1'b1;
            end
            pidc_pkg::OP_ACC_I:
            begin
                integral_next = pidc_pkg::sat64(pidc_pkg::PROD_W'(isum_wide));
            end
            pidc_pkg::OP_CLAMP_I:
            begin
                integral_next = integ_clamped;
            end
            default:
            begin
                integral_next = integral_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg   <= '0;
            prev_error_reg <= '0;
            have_prev_reg  <= 1'b0;
        end
        else
        begin
            integral_reg   <= integral_next;
            prev_error_reg <= prev_error_next;
            have_prev_reg  <= have_prev_next;
        end
    end

    // input word capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mode_reg <= mode;
            err_reg  <= error_in;
            dt_reg   <= step_ms;
        end
    end

    // working registers, one micro-operation per cycle
    always_ff @(posedge clk)
    begin
        unique case (ctrl.op)
            pidc_pkg::OP_DIFF:
            begin
                diff_reg  <= have_prev_reg ?
                             pidc_pkg::sat64(pidc_pkg::PROD_W'(diff_wide)) : '0;
                d_reg     <= '0;
                iterm_reg <= '0;
            end
            pidc_pkg::OP_MUL_DD, pidc_pkg::OP_MUL_PE, pidc_pkg::OP_MUL_IE,
            pidc_pkg::OP_MUL_KT, pidc_pkg::OP_MUL_SS:
            begin
                prod_reg <= mul_p;
            end
            pidc_pkg::OP_DIV_GO:
            begin
                div_neg_reg <= dvd[pidc_pkg::DIV_W-1];
            end
            pidc_pkg::OP_SET_P:
            begin
                p_reg <= pidc_pkg::sat64(prod_shr);
            end
            pidc_pkg::OP_SET_K, pidc_pkg::OP_SET_S:
            begin
                acc_reg <= pidc_pkg::sat64(prod_shr);
            end
            pidc_pkg::OP_CLAMP_I:
            begin
                iterm_reg <= integ_clamped;
            end
            pidc_pkg::OP_SET_D:
            begin
                if (dt_reg != '0)
                begin
                    d_reg <= pidc_pkg::sat64(pidc_pkg::PROD_W'(quo_signed));
                end
            end
            pidc_pkg::OP_SUM:
            begin
                acc_reg <= pidc_pkg::sat64(pidc_pkg::PROD_W'(tsum_wide));
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    pidc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.op == pidc_pkg::OP_DIV_GO),
        .dividend (dvd_mag),
        .divisor  (dt_reg),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // status for the sequencer
    always_comb
    begin
        flags.mode_clear = mode_reg;
        flags.dt_zero    = (dt_reg == '0);
        flags.integ_off  = (cfg.integ_gain <= 0);
        flags.div_busy   = div_busy;
    end

    assign drive_val = pidc_pkg::clamp32(acc_reg, cfg.out_low, cfg.out_high);

endmodule

`default_nettype wire

@@ design/pidc_useq.sv @@
// pidc_useq: microprogram counter, control store read and jump logic
`default_nettype none

module pidc_useq (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 out_busy,
    input  wire pidc_pkg::dp_flags_t  flags,
    output pidc_pkg::uword_t          ctrl,
    output logic                      idle
);

    pidc_pkg::upc_t  pc_reg, pc_next;
    logic            take;

    // control store read
    assign ctrl = pidc_pkg::ucode_word(pc_reg);

    // jump condition
    always_comb
    begin
        unique case (ctrl.cond)
            pidc_pkg::COND_NEVER:     take = 1'b0;
            pidc_pkg::COND_ALWAYS:    take = 1'b1;
            pidc_pkg::COND_NO_START:  take = !start;
            pidc_pkg::COND_UPDATE:    take = !flags.mode_clear;
            pidc_pkg::COND_DT_ZERO:   take = flags.dt_zero;
            pidc_pkg::COND_INTEG_OFF: take = flags.integ_off;
            pidc_pkg::COND_DIV_BUSY:  take = flags.div_busy;
            pidc_pkg::COND_OUT_BUSY:  take = out_busy;
            default:                  take = 1'b1;
        endcase
    end

    // next address
    always_comb
    begin
        pc_next = take ? ctrl.target : (pc_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= pidc_pkg::UA_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign idle = (pc_reg == pidc_pkg::UA_IDLE);

    // the quotient is only picked up once the divider has finished
    a_quotient_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == pidc_pkg::OP_SET_D) |-> !flags.div_busy)
        else $error("derivative taken from a running divider");

endmodule

`default_nettype wire

@@ design/pid_step_with_clamps.sv @@
// pid_step_with_clamps: top level with handshakes, register file and output stage
//
// PID controller step in signed Q16.16 with integral and output clamps. An update
// word (mode 0) skips the divide when step_ms is zero and skips the integral steps
// when the integral gain is not positive; a clear word (mode 1) gives no result.
// The microprogram issues one control word per cycle, holding its place while the
// divider or the output is busy, over a single shared 32x32 multiplier; the serial
// divider for the derivative produces two quotient bits per cycle over a 48-bit
// dividend. A finished drive value sits in an output register, so the block takes
// the next word while it waits; a second result waits only if the first is still
// not taken. The register port is always ready; the user must write it only while
// the block is idle, since the block itself does not enforce this.
`default_nettype none

module pid_step_with_clamps (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // register write port
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pidc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pidc_pkg::DATA_W-1:0]       cfg_data,
    // input words
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              mode,
    input  wire logic signed [pidc_pkg::DATA_W-1:0] error_in,
    input  wire logic [pidc_pkg::STEP_W-1:0]       step_ms,
    // result words
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [pidc_pkg::DATA_W-1:0]     drive
);

    pidc_pkg::cfg_t       cfg_reg;
    pidc_pkg::uword_t     ctrl;
    pidc_pkg::dp_flags_t  flags;
    pidc_pkg::word_t      drive_val;
    pidc_pkg::word_t      drive_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 seq_idle;
    logic                 in_acc;
    logic                 out_busy;
    logic                 out_load;

    // handshakes
    assign cfg_ready = 1'b1;
    assign in_ready  = seq_idle;
    assign in_acc    = in_valid && seq_idle;
    assign out_busy  = out_valid_reg && !out_ready;
    assign out_load  = (ctrl.op == pidc_pkg::OP_OUT) && !out_busy;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain  <= pidc_pkg::PROP_GAIN_RST;
            cfg_reg.integ_gain <= pidc_pkg::INTEG_GAIN_RST;
            cfg_reg.deriv_gain <= pidc_pkg::DERIV_GAIN_RST;
            cfg_reg.out_scale  <= pidc_pkg::OUT_SCALE_RST;
            cfg_reg.out_low    <= pidc_pkg::OUT_LOW_RST;
            cfg_reg.out_high   <= pidc_pkg::OUT_HIGH_RST;
            cfg_reg.integ_low  <= pidc_pkg::INTEG_LOW_RST;
            cfg_reg.integ_high <= pidc_pkg::INTEG_HIGH_RST;
        end
        else if (cfg_valid)
        begin
            unique case (pidc_pkg::cfg_idx_t'(cfg_index))
                pidc_pkg::CFG_PROP_GAIN:  cfg_reg.prop_gain  <= cfg_data;
                pidc_pkg::CFG_INTEG_GAIN: cfg_reg.integ_gain <= cfg_data;
                pidc_pkg::CFG_DERIV_GAIN: cfg_reg.deriv_gain <= cfg_data;
                pidc_pkg::CFG_OUT_SCALE:  cfg_reg.out_scale  <= cfg_data;
                pidc_pkg::CFG_OUT_LOW:    cfg_reg.out_low    <= cfg_data;
                pidc_pkg::CFG_OUT_HIGH:   cfg_reg.out_high   <= cfg_data;
                pidc_pkg::CFG_INTEG_LOW:  cfg_reg.integ_low  <= cfg_data;
                pidc_pkg::CFG_INTEG_HIGH: cfg_reg.integ_high <= cfg_data;
                default:                  cfg_reg.prop_gain  <= cfg_reg.prop_gain;
            endcase
        end
    end

    pidc_useq u_useq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_acc),
        .out_busy (out_busy),
        .flags    (flags),
        .ctrl     (ctrl),
        .idle     (seq_idle)
    );

    pidc_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .ctrl      (ctrl),
        .load      (in_acc),
        .mode      (mode),
        .error_in  (error_in),
        .step_ms   (step_ms),
        .flags     (flags),
        .drive_val (drive_val)
    );

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            drive_reg <= drive_val;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    // a result word only appears from the output step of the program
    a_out_from_ucode: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctrl.op == pidc_pkg::OP_OUT))
        else $error("result word raised outside the output step");

    // an accepted update word keeps the input side closed
    a_update_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !mode) |=> !in_ready)
        else $error("input reopened straight after an update word");

endmodule

`default_nettype wire

@@ verif/pid_step_with_clamps_tb.sv @@
// self-checking testbench for pid_step_with_clamps: directed and random update and clear words
`timescale 1ns / 1ps

module pid_step_with_clamps_tb;

    localparam pidc_pkg::word_t W_MAX = 32'sh7fffffff;
    localparam pidc_pkg::word_t W_MIN = 32'sh80000000;
    localparam pidc_pkg::word_t ONE_Q = 32'sd65536;
    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;
    localparam int SETTLE_CYCLES = 60;
    localparam int MAX_REPORTS = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic [pidc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [pidc_pkg::DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic mode = 1'b0;
    pidc_pkg::word_t error_in = '0;
    pidc_pkg::step_t step_ms = '0;
    logic out_ready;
    logic cfg_ready;
    logic in_ready;
    logic out_valid;
    logic signed [pidc_pkg::DATA_W-1:0] drive;

    // controller copy: gains, limits and running state
    pidc_pkg::word_t kp;
    pidc_pkg::word_t ki;
    pidc_pkg::word_t kd;
    pidc_pkg::word_t k_scale;
    pidc_pkg::word_t drive_lo;
    pidc_pkg::word_t drive_hi;
    pidc_pkg::word_t acc_lo;
    pidc_pkg::word_t acc_hi;
    pidc_pkg::word_t integ_acc;
    pidc_pkg::word_t last_error;
    logic seen_update;

    pidc_pkg::word_t pending_drive[$];
    pidc_pkg::word_t want_drive;
    int fault_count = 0;
    int words_sent = 0;
    int tx_gap_max = 0;
    int rx_gap_max = 0;
    int drive_hold = 0;

    pid_step_with_clamps u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .error_in  (error_in),
        .step_ms   (step_ms),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .drive     (drive)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // saturate to the signed 32-bit range
    function automatic pidc_pkg::word_t clip_s32(input longint v);
        if (v > longint'(W_MAX))
        begin
            return W_MAX;
        end
        if (v < longint'(W_MIN))
        begin
            return W_MIN;
        end
        return pidc_pkg::word_t'(v[31:0]);
    endfunction

    // Q16.16 product, floored then saturated
    function automatic pidc_pkg::word_t q_mul(input pidc_pkg::word_t a,
                                              input pidc_pkg::word_t b);
        longint prod;
        prod = longint'(a) * longint'(b);
        return clip_s32(prod >>> pidc_pkg::FRAC_W);
    endfunction

    // signed value spread evenly over -span..span
    function automatic pidc_pkg::word_t near(input int span);
        return pidc_pkg::word_t'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic pidc_pkg::word_t any_word();
        case ($urandom_range(0, 5))
            0: return W_MAX;
            1: return W_MIN;
            2: return '0;
            3: return ONE_Q;
            default: return pidc_pkg::word_t'($urandom);
        endcase
    endfunction

    function automatic pidc_pkg::word_t rand_error();
        case ($urandom_range(0, 5))
            0: return W_MAX;
            1: return W_MIN;
            2: return pidc_pkg::word_t'($urandom);
            3: return near(1 << 24);
            default: return near(8 << 16);
        endcase
    endfunction

    function automatic pidc_pkg::step_t rand_step();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 16'hffff;
            2: return pidc_pkg::step_t'($urandom_range(0, 65535));
            default: return pidc_pkg::step_t'($urandom_range(1, 40));
        endcase
    endfunction

    function automatic int rand_gap_max();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 2;
            2: return 8;
            default: return 18;
        endcase
    endfunction

    // next drive value for one word; clear words change state only
    task automatic compute_drive(input logic m, input pidc_pkg::word_t e,
                                 input pidc_pkg::step_t s);
        pidc_pkg::word_t diff;
        pidc_pkg::word_t k_err;
        pidc_pkg::word_t p_term;
        pidc_pkg::word_t i_term;
        pidc_pkg::word_t d_term;
        pidc_pkg::word_t scaled;
        pidc_pkg::word_t result;
        longint dprod;
        if (m == MODE_CLEAR)
        begin
            integ_acc = '0;
            last_error = '0;
            return;
        end
        if (seen_update)
        begin
            diff = clip_s32(longint'(e) - longint'(last_error));
        end
        else
        begin
            diff = '0;
            seen_update = 1'b1;
        end
        last_error = e;
        i_term = '0;
        d_term = '0;
        // integral only runs with a positive gain
        if (ki > 0)
        begin
            k_err = q_mul(ki, e);
            integ_acc = clip_s32(longint'(integ_acc) +
                                 longint'(clip_s32(longint'(k_err) * longint'(s))));
            if (integ_acc > acc_hi)
            begin
                integ_acc = acc_hi;
            end
            else if (integ_acc < acc_lo)
            begin
                integ_acc = acc_lo;
            end
            i_term = integ_acc;
        end
        p_term = q_mul(kp, e);
        // derivative, truncating divide, zero for a zero step
        if (s != 0)
        begin
            dprod = (longint'(kd) * longint'(diff)) >>> pidc_pkg::FRAC_W;
            d_term = clip_s32(dprod / longint'(s));
        end
        scaled = q_mul(clip_s32(longint'(p_term) + longint'(i_term) + longint'(d_term)),
                       k_scale);
        if (scaled > drive_hi)
        begin
            result = drive_hi;
        end
        else if (scaled < drive_lo)
        begin
            result = drive_lo;
        end
        else
        begin
            result = scaled;
        end
        pending_drive.push_back(result);
    endtask

    // register write, only while the block is idle
    task automatic write_reg(input pidc_pkg::cfg_idx_t idx, input pidc_pkg::word_t val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            pidc_pkg::CFG_PROP_GAIN:  kp = val;
            pidc_pkg::CFG_INTEG_GAIN: ki = val;
            pidc_pkg::CFG_DERIV_GAIN: kd = val;
            pidc_pkg::CFG_OUT_SCALE:  k_scale = val;
            pidc_pkg::CFG_OUT_LOW:    drive_lo = val;
            pidc_pkg::CFG_OUT_HIGH:   drive_hi = val;
            pidc_pkg::CFG_INTEG_LOW:  acc_lo = val;
            pidc_pkg::CFG_INTEG_HIGH: acc_hi = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // offer one input word after a random gap, hold until taken
    task automatic send_word(input logic m, input pidc_pkg::word_t e,
                             input pidc_pkg::step_t s);
        int gap;
        gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        error_in <= e;
        step_ms <= s;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        compute_drive(m, e, s);
        words_sent++;
    endtask

    // stop offering, wait for every result, then let the block go quiet
    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_drive.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
        begin
            $display("%s", msg);
        end
    endtask

    // receiver: random stalls per word, plus long hold-offs on request
    initial
    begin
        int n;
        int gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (drive_hold > 0)
            begin
                out_ready <= 1'b0;
                n = drive_hold;
                drive_hold = 0;
                repeat (n) @(negedge clk);
            end
            gap = (rx_gap_max > 0) ? $urandom_range(0, rx_gap_max) : 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
            begin
                @(posedge clk);
            end
        end
    end

    // compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_drive.size() == 0)
            begin
                note_fault($sformatf("unexpected drive word %0d", drive));
            end
            else
            begin
                want_drive = pending_drive.pop_front();
                if (drive !== want_drive)
                begin
                    note_fault($sformatf("drive mismatch: expected %0d got %0d",
                                         want_drive, drive));
                end
            end
        end
    end

    // reset values, first update and field extremes
    task automatic test_reset_values();
        tx_gap_max = 3;
        rx_gap_max = 3;
        send_word(MODE_UPDATE, W_MAX, 16'd0);
        send_word(MODE_UPDATE, W_MIN, 16'hffff);
        send_word(MODE_UPDATE, 32'sd0, 16'd1);
        send_word(MODE_UPDATE, -32'sd98304, 16'd7);
    endtask

    // derivative path: saturated differences, zero step, negative floor
    task automatic test_derivative();
        settle_block();
        write_reg(pidc_pkg::CFG_PROP_GAIN, 32'sd0);
        write_reg(pidc_pkg::CFG_DERIV_GAIN, 32'sd131072);
        send_word(MODE_UPDATE, ONE_Q, 16'd10);
        send_word(MODE_UPDATE, W_MIN, 16'd1);
        send_word(MODE_UPDATE, W_MAX, 16'd1);
        send_word(MODE_UPDATE, 32'sd100, 16'd0);
        settle_block();
        write_reg(pidc_pkg::CFG_DERIV_GAIN, W_MIN);
        send_word(MODE_UPDATE, -32'sd5, 16'd3);
    endtask

    // integral path: both clamps, saturation, gain zero and negative
    task automatic test_integral();
        settle_block();
        write_reg(pidc_pkg::CFG_DERIV_GAIN, 32'sd0);
        write_reg(pidc_pkg::CFG_INTEG_GAIN, 32'sd32768);
        write_reg(pidc_pkg::CFG_INTEG_HIGH, 32'sd655360);
        write_reg(pidc_pkg::CFG_INTEG_LOW, -32'sd655360);
        send_word(MODE_UPDATE, 32'sd262144, 16'd3);
        send_word(MODE_UPDATE, 32'sd262144, 16'd9);
        send_word(MODE_UPDATE, -32'sd2621440, 16'd20);
        settle_block();
        write_reg(pidc_pkg::CFG_INTEG_GAIN, W_MAX);
        write_reg(pidc_pkg::CFG_INTEG_HIGH, W_MAX);
        write_reg(pidc_pkg::CFG_INTEG_LOW, W_MIN);
        send_word(MODE_UPDATE, W_MAX, 16'hffff);
        settle_block();
        write_reg(pidc_pkg::CFG_INTEG_GAIN, -32'sd1);
        send_word(MODE_UPDATE, 32'sd65536, 16'd5);
        settle_block();
        write_reg(pidc_pkg::CFG_INTEG_GAIN, 32'sd0);
        send_word(MODE_UPDATE, -32'sd65536, 16'd5);
    endtask

    // output clamps, crossed limits, scale extremes
    task automatic test_output_clamp();
        settle_block();
        write_reg(pidc_pkg::CFG_PROP_GAIN, ONE_Q);
        write_reg(pidc_pkg::CFG_OUT_HIGH, ONE_Q);
        write_reg(pidc_pkg::CFG_OUT_LOW, -ONE_Q);
        send_word(MODE_UPDATE, 32'sd327680, 16'd2);
        send_word(MODE_UPDATE, -32'sd327680, 16'd2);
        settle_block();
        write_reg(pidc_pkg::CFG_OUT_LOW, 32'sd131072);
        write_reg(pidc_pkg::CFG_OUT_HIGH, -32'sd131072);
        send_word(MODE_UPDATE, 32'sd0, 16'd1);
        send_word(MODE_UPDATE, -32'sd327680, 16'd1);
        settle_block();
        write_reg(pidc_pkg::CFG_OUT_LOW, W_MIN);
        write_reg(pidc_pkg::CFG_OUT_HIGH, W_MAX);
        write_reg(pidc_pkg::CFG_OUT_SCALE, W_MIN);
        send_word(MODE_UPDATE, W_MAX, 16'd4);
    endtask

    // clear word keeps the first-update flag, so the next difference is the error
    task automatic test_clear();
        settle_block();
        write_reg(pidc_pkg::CFG_OUT_SCALE, ONE_Q);
        write_reg(pidc_pkg::CFG_DERIV_GAIN, ONE_Q);
        write_reg(pidc_pkg::CFG_INTEG_GAIN, 32'sd16384);
        send_word(MODE_CLEAR, W_MIN, 16'hffff);
        send_word(MODE_UPDATE, 32'sd196608, 16'd2);
        send_word(MODE_CLEAR, W_MAX, 16'd0);
        send_word(MODE_UPDATE, -32'sd65536, 16'd1);
    endtask

    // receiver holds off while words keep coming, then sender drains
    task automatic test_backpressure();
        int i;
        settle_block();
        tx_gap_max = 0;
        rx_gap_max = 0;
        drive_hold = 400;
        for (i = 0; i < 14; i++)
        begin
            send_word(MODE_UPDATE, near(8 << 16),
                      pidc_pkg::step_t'($urandom_range(0, 20)));
        end
        settle_block();
    endtask

    // all eight registers for one random phase
    task automatic program_phase(input int style);
        pidc_pkg::word_t a;
        pidc_pkg::word_t b;
        pidc_pkg::word_t c;
        pidc_pkg::word_t d;
        a = near(1 << 22);
        b = near(1 << 22);
        c = near(1 << 22);
        d = near(1 << 22);
        case (style)
            0:
            begin
                // moderate gains, ordered limits
                write_reg(pidc_pkg::CFG_PROP_GAIN, near(4 << 16));
                write_reg(pidc_pkg::CFG_INTEG_GAIN,
                          ($urandom_range(0, 3) == 0) ? near(1 << 16) :
                          pidc_pkg::word_t'($urandom_range(1, 1 << 15)));
                write_reg(pidc_pkg::CFG_DERIV_GAIN, near(2 << 16));
                write_reg(pidc_pkg::CFG_OUT_SCALE, near(2 << 16));
                write_reg(pidc_pkg::CFG_OUT_LOW, (a < b) ? a : b);
                write_reg(pidc_pkg::CFG_OUT_HIGH, (a < b) ? b : a);
                write_reg(pidc_pkg::CFG_INTEG_LOW, (c < d) ? c : d);
                write_reg(pidc_pkg::CFG_INTEG_HIGH, (c < d) ? d : c);
            end
            1:
            begin
                // anything, extremes favoured
                write_reg(pidc_pkg::CFG_PROP_GAIN, any_word());
                write_reg(pidc_pkg::CFG_INTEG_GAIN, any_word());
                write_reg(pidc_pkg::CFG_DERIV_GAIN, any_word());
                write_reg(pidc_pkg::CFG_OUT_SCALE, any_word());
                write_reg(pidc_pkg::CFG_OUT_LOW, any_word());
                write_reg(pidc_pkg::CFG_OUT_HIGH, any_word());
                write_reg(pidc_pkg::CFG_INTEG_LOW, any_word());
                write_reg(pidc_pkg::CFG_INTEG_HIGH, any_word());
            end
            2:
            begin
                // crossed limits on both clamps
                write_reg(pidc_pkg::CFG_PROP_GAIN, near(4 << 16));
                write_reg(pidc_pkg::CFG_INTEG_GAIN,
                          pidc_pkg::word_t'($urandom_range(1, 1 << 15)));
                write_reg(pidc_pkg::CFG_DERIV_GAIN, near(2 << 16));
                write_reg(pidc_pkg::CFG_OUT_SCALE, ONE_Q);
                write_reg(pidc_pkg::CFG_OUT_LOW,
                          pidc_pkg::word_t'($urandom_range(1 << 16, 1 << 20)));
                write_reg(pidc_pkg::CFG_OUT_HIGH,
                          -pidc_pkg::word_t'($urandom_range(1 << 16, 1 << 20)));
                write_reg(pidc_pkg::CFG_INTEG_LOW,
                          pidc_pkg::word_t'($urandom_range(1 << 16, 1 << 20)));
                write_reg(pidc_pkg::CFG_INTEG_HIGH,
                          -pidc_pkg::word_t'($urandom_range(1 << 16, 1 << 20)));
            end
            default:
            begin
                // open limits with an extreme derivative gain
                write_reg(pidc_pkg::CFG_PROP_GAIN, ONE_Q);
                write_reg(pidc_pkg::CFG_INTEG_GAIN,
                          pidc_pkg::word_t'($urandom_range(1, 1 << 12)));
                write_reg(pidc_pkg::CFG_DERIV_GAIN,
                          ($urandom_range(0, 1) == 0) ? W_MIN : W_MAX);
                write_reg(pidc_pkg::CFG_OUT_SCALE, ONE_Q);
                write_reg(pidc_pkg::CFG_OUT_LOW, W_MIN);
                write_reg(pidc_pkg::CFG_OUT_HIGH, W_MAX);
                write_reg(pidc_pkg::CFG_INTEG_LOW, W_MIN);
                write_reg(pidc_pkg::CFG_INTEG_HIGH, W_MAX);
            end
        endcase
    endtask

    // run of updates with a wandering error, sometimes closed by a clear
    task automatic run_sequence(input int len);
        longint walk;
        int i;
        walk = longint'(rand_error());
        for (i = 0; i < len; i++)
        begin
            walk = longint'(clip_s32(walk + longint'(near(1 << 16))));
            send_word(MODE_UPDATE, pidc_pkg::word_t'(walk[31:0]), rand_step());
        end
        if ($urandom_range(0, 2) == 0)
        begin
            send_word(MODE_CLEAR, pidc_pkg::word_t'($urandom),
                      pidc_pkg::step_t'($urandom));
        end
    endtask

    // random phases, each under its own register setting
    task automatic test_random_phases();
        int phase;
        int target;
        for (phase = 0; phase < 8; phase++)
        begin
            settle_block();
            program_phase((phase < 4) ? phase : $urandom_range(0, 3));
            target = words_sent + 165;
            while (words_sent < target)
            begin
                tx_gap_max = rand_gap_max();
                rx_gap_max = rand_gap_max();
                if ($urandom_range(0, 9) == 0)
                begin
                    send_word(logic'($urandom_range(0, 1)), pidc_pkg::word_t'($urandom),
                              pidc_pkg::step_t'($urandom));
                end
                else
                begin
                    run_sequence($urandom_range(5, 25));
                end
                if ($urandom_range(0, 15) == 0)
                begin
                    settle_block();
                end
            end
        end
    endtask

    // test sequence
    initial
    begin
        kp = ONE_Q;
        ki = '0;
        kd = '0;
        k_scale = ONE_Q;
        drive_lo = W_MIN;
        drive_hi = W_MAX;
        acc_lo = W_MIN;
        acc_hi = W_MAX;
        integ_acc = '0;
        last_error = '0;
        seen_update = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        test_reset_values();
        test_derivative();
        test_integral();
        test_output_clamp();
        test_clear();
        test_backpressure();
        test_random_phases();
        settle_block();
        if (fault_count == 0)
        begin
            $display("pid_step_with_clamps verification clean");
        end
        else
        begin
            $display("pid_step_with_clamps verification failed");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("pid_step_with_clamps verification failed");
        $finish;
    end

endmodule
